// ----- hw/rtl/col_pkg.sv -----
package col_pkg;

    // Table size and stored coordinate width.
    localparam int MAX_CIRCLES = 16;
    localparam int COORD_BITS  = 16;

    // Fixed field widths of the request and response words.
    localparam int OP_W   = 3;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 16;
    localparam int RAD_W  = 15;
    localparam int ST_W   = 3;

    // Derived widths.
    localparam int IDX_W  = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int SUM_W  = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 1;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int K_W    = RAD_W + 1;
    localparam int K2_W   = 2 * K_W;
    localparam int DSQ_W  = (SQ_W + 1 > K2_W) ? SQ_W + 1 : K2_W;

    // Comparator pipeline depth and scan counter.
    localparam int CMP_LAT = 3;
    localparam int CNT_W   = $clog2(MAX_CIRCLES + CMP_LAT);
    localparam logic [CNT_W-1:0] SCAN_FEED = CNT_W'(MAX_CIRCLES);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_CIRCLES + CMP_LAT - 1);

    // Opcodes.
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_CENTER = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_RADIUS = 3'd2;
    localparam logic [OP_W-1:0] OP_TRANSLATE  = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;
    localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd5;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_OVERLAP = 3'd1;
    localparam logic [ST_W-1:0] ST_NEGRAD  = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;
    localparam logic [ST_W-1:0] ST_RANGE   = 3'd5;

    // Comparator modes.
    localparam logic CMP_OVERLAP = 1'b0;
    localparam logic CMP_CONTAIN = 1'b1;

    // Legal range of a stored center coordinate.
    localparam logic signed [SUM_W-1:0] C_MIN = SUM_W'(-(2 ** (COORD_BITS - 1)));
    localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'((2 ** (COORD_BITS - 1)) - 1);

    // One stored circle.
    typedef struct packed {
        logic                         valid;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic        [RAD_W-1:0]      r;
    } t_entry;

    // Control of the ring of cells.
    typedef struct packed {
        logic             shift;
        logic             wr;
        logic [IDX_W-1:0] wr_idx;
        t_entry           wr_data;
    } t_ring_ctl;

    // One comparison handed to the comparator.
    typedef struct packed {
        logic   en;
        logic   mode;
        t_entry a;
        t_entry b;
    } t_cmp_req;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_cmp_res;

    function automatic logic coord_ok(input logic signed [SUM_W-1:0] v);
        return (v >= C_MIN) && (v <= C_MAX);
    endfunction

endpackage

// ----- hw/rtl/col_if.sv -----
// Request channel: one word per table operation.
interface col_req_if;
    logic                     valid;
    logic                     ready;
    logic [2:0]               opcode;
    logic [3:0]               slot;
    logic [3:0]               other_slot;
    logic signed [15:0]       pos_x;
    logic signed [15:0]       pos_y;
    logic signed [15:0]       radius_in;

    modport source (
        output valid, opcode, slot, other_slot, pos_x, pos_y, radius_in,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot, other_slot, pos_x, pos_y, radius_in,
        output ready
    );
endinterface

// Response channel: one word per request.
interface col_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [3:0] slot_out;
    logic       contains;

    modport source (
        output valid, status, slot_out, contains,
        input  ready
    );
    modport sink (
        input  valid, status, slot_out, contains,
        output ready
    );
endinterface

// ----- hw/rtl/col_cell.sv -----
module col_cell
    import col_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_idx,
    input  t_ring_ctl        i_ctl,
    input  t_entry           i_shift_in,
    output t_entry           o_entry
);

    logic                         r_valid;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic        [RAD_W-1:0]      r_r;
    logic                         wr_sel;

    // A write hits this cell only when the ring stands at its home position.
    assign wr_sel = i_ctl.wr && (i_ctl.wr_idx == i_idx);

    // Valid bit, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_shift_in.valid;
        end else if (wr_sel) begin
            r_valid <= i_ctl.wr_data.valid;
        end
    end

    // Circle payload.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_x <= i_shift_in.x;
            r_y <= i_shift_in.y;
            r_r <= i_shift_in.r;
        end else if (wr_sel) begin
            r_x <= i_ctl.wr_data.x;
            r_y <= i_ctl.wr_data.y;
            r_r <= i_ctl.wr_data.r;
        end
    end

    assign o_entry = '{valid: r_valid, x: r_x, y: r_y, r: r_r};

endmodule

// ----- hw/rtl/col_cmp.sv -----
module col_cmp
    import col_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmp_req i_req,
    output t_cmp_res o_res
);

    // Stage one: center differences and radius sum or difference.
    logic                     r_en1;
    logic                     r_mode1;
    logic                     r_le1;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic [K_W-1:0]           r_k;

    // Stage two: squares.
    logic                     r_en2;
    logic                     r_mode2;
    logic                     r_le2;
    logic signed [SQ_W-1:0]   r_dx2;
    logic signed [SQ_W-1:0]   r_dy2;
    logic [K2_W-1:0]          r_k2;

    // Stage three: registered verdict.
    logic                     r_valid3;
    logic                     r_hit3;

    logic [DSQ_W-1:0]         d2;
    logic                     hit;

    assign d2  = DSQ_W'($unsigned(r_dx2)) + DSQ_W'($unsigned(r_dy2));
    // Touching counts as overlap; containment needs the inner radius not larger.
    assign hit = (d2 <= DSQ_W'(r_k2)) && ((r_mode2 == CMP_OVERLAP) || r_le2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en1    <= 1'b0;
            r_en2    <= 1'b0;
            r_valid3 <= 1'b0;
        end else begin
            r_en1    <= i_req.en;
            r_en2    <= r_en1;
            r_valid3 <= r_en2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode1 <= i_req.mode;
        r_le1   <= i_req.b.r <= i_req.a.r;
        r_dx    <= DIFF_W'($signed(i_req.b.x)) - DIFF_W'($signed(i_req.a.x));
        r_dy    <= DIFF_W'($signed(i_req.b.y)) - DIFF_W'($signed(i_req.a.y));
        if (i_req.mode == CMP_OVERLAP) begin
            r_k <= K_W'(i_req.a.r) + K_W'(i_req.b.r);
        end else begin
            r_k <= K_W'(i_req.a.r) - K_W'(i_req.b.r);
        end

        r_mode2 <= r_mode1;
        r_le2   <= r_le1;
        r_dx2   <= r_dx * r_dx;
        r_dy2   <= r_dy * r_dy;
        r_k2    <= r_k * r_k;

        r_hit3  <= hit;
    end

    assign o_res = '{valid: r_valid3, hit: r_hit3};

endmodule

// ----- hw/rtl/circle_overlap_table_unit.sv -----
// Channel   Dir  Modport  Word
// i_req     in   sink     opcode, slot, other_slot, pos_x, pos_y, radius_in
// o_rsp     out  source   status, slot_out, contains
//
// A change that is checked for overlap runs from accept through a setup step,
// a scan that rotates all 16 cells of the ring past the shared three-stage
// comparator, the comparator drain and a commit before the next accept.
// A contains query makes one comparison; remove and rejected words do no scan.
// Reset is synchronous and clears only the valid bits and the control state.
// A finished response waits in the output register while the next word is taken.

module circle_overlap_table_unit
    import col_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    col_req_if.sink   i_req,
    col_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_FETCH2,
        S_CMP,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [OP_W-1:0]         r_op, n_op;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [SLOT_W-1:0]       r_other, n_other;
    logic signed [POS_W-1:0] r_px, n_px;
    logic signed [POS_W-1:0] r_py, n_py;
    logic signed [POS_W-1:0] r_rin, n_rin;
    t_entry                  r_a, n_a;
    logic                    r_sok, n_sok;
    t_entry                  r_probe, n_probe;
    logic [IDX_W-1:0]        r_widx, n_widx;
    logic                    r_skip_en, n_skip_en;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_hit, n_hit;
    logic [ST_W-1:0]         r_status, n_status;
    logic [SLOT_W-1:0]       r_slot_out, n_slot_out;
    logic                    r_cont, n_cont;
    logic                    r_commit, n_commit;
    logic                    r_rsp_valid, n_rsp_valid;
    logic [ST_W-1:0]         r_rsp_status, n_rsp_status;
    logic [SLOT_W-1:0]       r_rsp_slot, n_rsp_slot;
    logic                    r_rsp_cont, n_rsp_cont;

    t_entry                  cell_q [MAX_CIRCLES];
    t_ring_ctl               ring_ctl;
    t_cmp_req                cmp_req;
    t_cmp_res                cmp_res;

    logic [IDX_W-1:0]        rd_idx;
    t_entry                  rd_entry;
    logic                    slot_in_range;
    logic                    other_in_range;
    logic [IDX_W-1:0]        free_idx;
    logic                    full;
    logic signed [SUM_W-1:0] px_w;
    logic signed [SUM_W-1:0] py_w;
    logic signed [SUM_W-1:0] tx;
    logic signed [SUM_W-1:0] ty;
    logic                    coords_ok;

    // Ring of cells; cell 0 faces the comparator and takes from its neighbor.
    for (genvar g = 0; g < MAX_CIRCLES; g++) begin : g_cell
        col_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (IDX_W'(g)),
            .i_ctl      (ring_ctl),
            .i_shift_in (cell_q[(g + 1) % MAX_CIRCLES]),
            .o_entry    (cell_q[g])
        );
    end

    col_cmp u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cmp_req),
        .o_res   (cmp_res)
    );

    // Single read port into the ring, used while it stands at home.
    assign rd_idx         = (r_state == S_FETCH2) ? IDX_W'(r_other) : IDX_W'(r_slot);
    assign rd_entry       = cell_q[rd_idx];
    assign slot_in_range  = int'(r_slot) < MAX_CIRCLES;
    assign other_in_range = int'(r_other) < MAX_CIRCLES;

    // Lowest free slot.
    always_comb begin
        full     = 1'b1;
        free_idx = '0;
        for (int i = MAX_CIRCLES - 1; i >= 0; i--) begin
            if (!cell_q[i].valid) begin
                full     = 1'b0;
                free_idx = IDX_W'(i);
            end
        end
    end

    // New center for insert, set center and translate.
    assign px_w      = SUM_W'(r_px);
    assign py_w      = SUM_W'(r_py);
    assign tx        = (r_op == OP_TRANSLATE) ? SUM_W'($signed(rd_entry.x)) + px_w : px_w;
    assign ty        = (r_op == OP_TRANSLATE) ? SUM_W'($signed(rd_entry.y)) + py_w : py_w;
    assign coords_ok = coord_ok(tx) && coord_ok(ty);

    // Sequencer next state.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_slot       = r_slot;
        n_other      = r_other;
        n_px         = r_px;
        n_py         = r_py;
        n_rin        = r_rin;
        n_a          = r_a;
        n_sok        = r_sok;
        n_probe      = r_probe;
        n_widx       = r_widx;
        n_skip_en    = r_skip_en;
        n_cnt        = r_cnt;
        n_hit        = r_hit;
        n_status     = r_status;
        n_slot_out   = r_slot_out;
        n_cont       = r_cont;
        n_commit     = r_commit;
        n_rsp_status = r_rsp_status;
        n_rsp_slot   = r_rsp_slot;
        n_rsp_cont   = r_rsp_cont;
        n_rsp_valid  = r_rsp_valid && !o_rsp.ready;

        ring_ctl     = '{shift: 1'b0, wr: 1'b0, wr_idx: r_widx, wr_data: r_probe};
        cmp_req      = '{en: 1'b0, mode: CMP_OVERLAP, a: r_probe, b: cell_q[0]};

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = i_req.opcode;
                    n_slot  = i_req.slot;
                    n_other = i_req.other_slot;
                    n_px    = i_req.pos_x;
                    n_py    = i_req.pos_y;
                    n_rin   = i_req.radius_in;
                    n_state = S_SETUP;
                end
            end

            S_SETUP: begin
                n_slot_out = r_slot;
                n_status   = ST_OK;
                n_cont     = 1'b0;
                n_commit   = 1'b0;
                n_cnt      = '0;
                n_hit      = 1'b0;
                n_sok      = slot_in_range && rd_entry.valid;
                n_state    = S_DONE;
                case (r_op)
                    OP_INSERT: begin
                        n_slot_out = full ? '0 : SLOT_W'(free_idx);
                        n_widx     = free_idx;
                        n_skip_en  = 1'b0;
                        n_probe    = '{valid: 1'b1, x: COORD_BITS'(tx),
                                       y: COORD_BITS'(ty), r: r_rin[RAD_W-1:0]};
                        if (r_rin[POS_W-1]) begin
                            n_status = ST_NEGRAD;
                        end else if (!coords_ok) begin
                            n_status = ST_RANGE;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_SET_CENTER, OP_TRANSLATE: begin
                        n_widx    = IDX_W'(r_slot);
                        n_skip_en = 1'b1;
                        n_probe   = '{valid: 1'b1, x: COORD_BITS'(tx),
                                      y: COORD_BITS'(ty), r: rd_entry.r};
                        if (!(slot_in_range && rd_entry.valid)) begin
                            n_status = ST_EMPTY;
                        end else if (!coords_ok) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_SET_RADIUS: begin
                        n_widx    = IDX_W'(r_slot);
                        n_skip_en = 1'b1;
                        n_probe   = '{valid: 1'b1, x: rd_entry.x, y: rd_entry.y,
                                      r: r_rin[RAD_W-1:0]};
                        if (!(slot_in_range && rd_entry.valid)) begin
                            n_status = ST_EMPTY;
                        end else if (r_rin[POS_W-1]) begin
                            n_status = ST_NEGRAD;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    OP_REMOVE: begin
                        n_widx  = IDX_W'(r_slot);
                        n_probe = '{valid: 1'b0, x: rd_entry.x, y: rd_entry.y,
                                    r: rd_entry.r};
                        if (!(slot_in_range && rd_entry.valid)) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_commit = 1'b1;
                        end
                    end
                    OP_CONTAINS: begin
                        n_a     = rd_entry;
                        n_state = S_FETCH2;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end

            // Second read for the contains query, then one comparison.
            S_FETCH2: begin
                if (r_sok && other_in_range && rd_entry.valid) begin
                    cmp_req = '{en: 1'b1, mode: CMP_CONTAIN, a: r_a, b: rd_entry};
                    n_state = S_CMP;
                end else begin
                    n_status = ST_EMPTY;
                    n_state  = S_DONE;
                end
            end

            S_CMP: begin
                if (cmp_res.valid) begin
                    n_cont  = cmp_res.hit;
                    n_state = S_DONE;
                end
            end

            // Rotate every slot past the comparator, skipping the one being changed.
            S_SCAN: begin
                ring_ctl.shift = r_cnt < SCAN_FEED;
                cmp_req.en     = (r_cnt < SCAN_FEED) && cell_q[0].valid &&
                                 !(r_skip_en && (r_cnt[IDX_W-1:0] == r_widx));
                n_hit          = r_hit || (cmp_res.valid && cmp_res.hit);
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == SCAN_LAST) begin
                    n_status = n_hit ? ST_OVERLAP : ST_OK;
                    n_commit = !n_hit;
                    n_state  = S_DONE;
                end
            end

            // Commit the change and hand the response to the output register.
            S_DONE: begin
                if (!r_rsp_valid || o_rsp.ready) begin
                    ring_ctl.wr  = r_commit;
                    n_rsp_valid  = 1'b1;
                    n_rsp_status = r_status;
                    n_rsp_slot   = r_slot_out;
                    n_rsp_cont   = r_cont;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_commit    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
            r_commit    <= n_commit;
        end
        r_op         <= n_op;
        r_slot       <= n_slot;
        r_other      <= n_other;
        r_px         <= n_px;
        r_py         <= n_py;
        r_rin        <= n_rin;
        r_a          <= n_a;
        r_sok        <= n_sok;
        r_probe      <= n_probe;
        r_widx       <= n_widx;
        r_skip_en    <= n_skip_en;
        r_cnt        <= n_cnt;
        r_hit        <= n_hit;
        r_status     <= n_status;
        r_slot_out   <= n_slot_out;
        r_cont       <= n_cont;
        r_rsp_status <= n_rsp_status;
        r_rsp_slot   <= n_rsp_slot;
        r_rsp_cont   <= n_rsp_cont;
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_rsp_valid;
    assign o_rsp.status   = r_rsp_status;
    assign o_rsp.slot_out = r_rsp_slot;
    assign o_rsp.contains = r_rsp_cont;

endmodule
